### design/sctc_pkg.sv
// ----------------------------------------------------------------------------
// sctc_pkg: shared types and tables for the scan code translator
// Scan code constants, the modifier state record, and the character tables
// for the Latin and Cyrillic layouts and the numeric keypad.
// ----------------------------------------------------------------------------
`default_nettype none

package sctc_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned CharW = 16;

  localparam logic [CodeW-1:0] KEY_LSHIFT = 8'h2A;
  localparam logic [CodeW-1:0] KEY_RSHIFT = 8'h36;
  localparam logic [CodeW-1:0] KEY_LALT   = 8'h38;
  localparam logic [CodeW-1:0] KEY_LCTRL  = 8'h1D;
  localparam logic [CodeW-1:0] KEY_DIVIDE = 8'hB5;
  localparam logic [CodeW-1:0] KEY_OEM102 = 8'h56;
  localparam logic [5:0]       KEY_BSLASH = 6'd43;

  localparam int unsigned MainCount = 58;
  localparam int unsigned PadCount  = 13;
  localparam logic [CodeW-1:0] MAIN_LAST = 8'd57;
  localparam logic [CodeW-1:0] PAD_FIRST = 8'd71;
  localparam logic [CodeW-1:0] PAD_LAST  = 8'd83;

  localparam logic [CharW-1:0] CHAR_NONE  = 16'h0000;
  localparam logic [CharW-1:0] CHAR_SLASH = 16'h002F;

  typedef struct packed {
    logic shift_held;
    logic layout_sel;
    logic modifier_held;
    logic shift_key_held;
    logic chord_seen;
  } kb_state_t;

  // Rows: Latin, Latin shifted, Cyrillic, Cyrillic shifted.
  localparam logic [CharW-1:0] MAIN_TAB [4][MainCount] = '{
    '{16'h0000, 16'h0000, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036,
      16'h0037, 16'h0038, 16'h0039, 16'h0030, 16'h002D, 16'h003D, 16'h0000, 16'h0000,
      16'h0071, 16'h0077, 16'h0065, 16'h0072, 16'h0074, 16'h0079, 16'h0075, 16'h0069,
      16'h006F, 16'h0070, 16'h005B, 16'h005D, 16'h0000, 16'h0000, 16'h0061, 16'h0073,
      16'h0064, 16'h0066, 16'h0067, 16'h0068, 16'h006A, 16'h006B, 16'h006C, 16'h003B,
      16'h0027, 16'h0060, 16'h0000, 16'h005C, 16'h007A, 16'h0078, 16'h0063, 16'h0076,
      16'h0062, 16'h006E, 16'h006D, 16'h002C, 16'h002E, 16'h002F, 16'h0000, 16'h002A,
      16'h0000, 16'h0020},
    '{16'h0000, 16'h0000, 16'h0021, 16'h0040, 16'h0023, 16'h0024, 16'h0025, 16'h005E,
      16'h0026, 16'h002A, 16'h0028, 16'h0029, 16'h005F, 16'h002B, 16'h0000, 16'h0000,
      16'h0051, 16'h0057, 16'h0045, 16'h0052, 16'h0054, 16'h0059, 16'h0055, 16'h0049,
      16'h004F, 16'h0050, 16'h007B, 16'h007D, 16'h0000, 16'h0000, 16'h0041, 16'h0053,
      16'h0044, 16'h0046, 16'h0047, 16'h0048, 16'h004A, 16'h004B, 16'h004C, 16'h003A,
      16'h0022, 16'h007E, 16'h0000, 16'h007C, 16'h005A, 16'h0058, 16'h0043, 16'h0056,
      16'h0042, 16'h004E, 16'h004D, 16'h003C, 16'h003E, 16'h003F, 16'h0000, 16'h002A,
      16'h0000, 16'h0020},
    '{16'h0000, 16'h0000, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036,
      16'h0037, 16'h0038, 16'h0039, 16'h0030, 16'h002D, 16'h003D, 16'h0000, 16'h0000,
      16'h0439, 16'h0446, 16'h0443, 16'h043A, 16'h0435, 16'h043D, 16'h0433, 16'h0448,
      16'h0449, 16'h0437, 16'h0445, 16'h044A, 16'h0000, 16'h0000, 16'h0444, 16'h044B,
      16'h0432, 16'h0430, 16'h043F, 16'h0440, 16'h043E, 16'h043B, 16'h0434, 16'h0436,
      16'h044D, 16'h0451, 16'h0000, 16'h005C, 16'h044F, 16'h0447, 16'h0441, 16'h043C,
      16'h0438, 16'h0442, 16'h044C, 16'h0431, 16'h044E, 16'h002E, 16'h0000, 16'h002A,
      16'h0000, 16'h0020},
    '{16'h0000, 16'h0000, 16'h0021, 16'h0022, 16'h2116, 16'h003B, 16'h0025, 16'h003A,
      16'h003F, 16'h002A, 16'h0028, 16'h0029, 16'h005F, 16'h002B, 16'h0000, 16'h0000,
      16'h0419, 16'h0426, 16'h0423, 16'h041A, 16'h0415, 16'h041D, 16'h0413, 16'h0428,
      16'h0429, 16'h0417, 16'h0425, 16'h042A, 16'h0000, 16'h0000, 16'h0424, 16'h042B,
      16'h0412, 16'h0410, 16'h041F, 16'h0420, 16'h041E, 16'h041B, 16'h0414, 16'h0416,
      16'h042D, 16'h0401, 16'h0000, 16'h002F, 16'h042F, 16'h0427, 16'h0421, 16'h041C,
      16'h0418, 16'h0422, 16'h042C, 16'h0411, 16'h042E, 16'h002C, 16'h0000, 16'h002A,
      16'h0000, 16'h0020}
  };

  localparam logic [CharW-1:0] PAD_TAB [PadCount] = '{
    16'h0037, 16'h0038, 16'h0039, 16'h002D, 16'h0034, 16'h0035, 16'h0036,
    16'h002B, 16'h0031, 16'h0032, 16'h0033, 16'h0030, 16'h002E
  };

endpackage

`default_nettype wire

### design/scancode_to_char_layout_toggle_top.sv
// ----------------------------------------------------------------------------
// scancode_to_char_layout_toggle_top: key event to UTF-16 translator
// Tracks shift and a Latin/Cyrillic layout toggled by an Alt or Ctrl plus
// Shift chord, and translates each key press to a character.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while in_stall_o is low. A request
// is captured in an input register, the modifier state update and the table
// lookup happen in the following cycle, and the result lands in an output
// register once the output is free. The output register lets a new request
// in while an earlier result is still stalled; the state flags advance as
// each request passes from the input register to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_to_char_layout_toggle_top
  import sctc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [CodeW-1:0] key_code_i,
  input  wire logic             key_pressed_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [CharW-1:0] char_code_o,
  output logic                  shift_active_o,
  output logic                  alt_layout_o
);

  logic             in_vld_q;
  logic [CodeW-1:0] code_q;
  logic             down_q;
  logic             out_vld_q;
  logic [CharW-1:0] char_q;
  logic             shift_q;
  logic             layout_q;
  logic             out_free;
  logic             advance;
  logic             take_in;
  kb_state_t        state_d;
  logic [CharW-1:0] char_d;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign take_in    = in_valid_i && !in_stall_o;

  sctc_chord u_chord (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (advance),
    .code_i    (code_q),
    .down_i    (down_q),
    .state_d_o (state_d)
  );

  sctc_xlate u_xlate (
    .code_i   (code_q),
    .down_i   (down_q),
    .shift_i  (state_d.shift_held),
    .layout_i (state_d.layout_sel),
    .char_o   (char_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take_in) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      code_q <= key_code_i;
      down_q <= key_pressed_i;
    end
    if (advance) begin
      char_q   <= char_d;
      shift_q  <= state_d.shift_held;
      layout_q <= state_d.layout_sel;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign char_code_o    = char_q;
  assign shift_active_o = shift_q;
  assign alt_layout_o   = layout_q;

endmodule

`default_nettype wire

### design/sctc_chord.sv
// ----------------------------------------------------------------------------
// sctc_chord: modifier and layout state tracker
// Holds the shift and chord flags and the layout bit, and computes their
// next value for the key event in the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sctc_chord
  import sctc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             upd_i,
  input  wire logic [CodeW-1:0] code_i,
  input  wire logic             down_i,
  output kb_state_t             state_d_o
);

  kb_state_t state_q;
  kb_state_t state_d;

  always_comb begin
    state_d = state_q;
    if ((code_i == KEY_LSHIFT) || (code_i == KEY_RSHIFT)) begin
      state_d.shift_held     = down_i;
      state_d.shift_key_held = down_i;
      if (down_i) begin
        if (state_q.modifier_held) begin
          state_d.chord_seen = 1'b1;
        end
      end else if (!state_q.modifier_held && state_q.chord_seen) begin
        state_d.chord_seen = 1'b0;
        state_d.layout_sel = ~state_q.layout_sel;
      end
    end else if ((code_i == KEY_LALT) || (code_i == KEY_LCTRL)) begin
      state_d.modifier_held = down_i;
      if (down_i) begin
        if (state_q.shift_key_held) begin
          state_d.chord_seen = 1'b1;
        end
      end else if (!state_q.shift_key_held && state_q.chord_seen) begin
        state_d.chord_seen = 1'b0;
        state_d.layout_sel = ~state_q.layout_sel;
      end
    end else begin
      state_d.modifier_held  = 1'b0;
      state_d.shift_key_held = 1'b0;
      state_d.chord_seen     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (upd_i) begin
      state_q <= state_d;
    end
  end

  assign state_d_o = state_d;

endmodule

`default_nettype wire

### design/sctc_xlate.sv
// ----------------------------------------------------------------------------
// sctc_xlate: scan code to character lookup
// Picks the main table row from layout and shift, or the keypad table,
// and gives zero for releases and unmapped codes.
// ----------------------------------------------------------------------------
`default_nettype none

module sctc_xlate
  import sctc_pkg::*;
(
  input  wire logic             [CodeW-1:0] code_i,
  input  wire logic                         down_i,
  input  wire logic                         shift_i,
  input  wire logic                         layout_i,
  output logic                  [CharW-1:0] char_o
);

  logic [1:0] row;
  logic [3:0] pad_off;

  always_comb begin
    row     = {layout_i, shift_i};
    pad_off = 4'(code_i - PAD_FIRST);
    char_o  = CHAR_NONE;
    if (down_i) begin
      if (code_i <= MAIN_LAST) begin
        char_o = MAIN_TAB[row][code_i[5:0]];
      end else if (code_i inside {[PAD_FIRST:PAD_LAST]}) begin
        char_o = PAD_TAB[pad_off];
      end else if (code_i == KEY_DIVIDE) begin
        char_o = CHAR_SLASH;
      end else if (code_i == KEY_OEM102) begin
        // The extra key next to left Shift repeats the backslash key.
        char_o = MAIN_TAB[row][KEY_BSLASH];
      end
    end
  end

endmodule

`default_nettype wire

### verif/tb_scancode_to_char_layout_toggle_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scancode_to_char_layout_toggle_top: self-checking bench for the translator
// Drives key events through the request channel and checks every character,
// shift flag and layout flag against a behavioral keymap tracker. Covers the
// table edges, the keypad, divide and OEM 102, and both chord orders.
// ----------------------------------------------------------------------------

module tb_scancode_to_char_layout_toggle_top;
  import sctc_pkg::*;

  localparam int unsigned DirectedItems = 25;
  localparam int unsigned RandomItems   = 400;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned LongHold      = 48;

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [CodeW-1:0] key_code_i    = '0;
  logic             key_pressed_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [CharW-1:0] char_code_o;
  logic             shift_active_o;
  logic             alt_layout_o;

  scancode_to_char_layout_toggle_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .key_code_i    (key_code_i),
    .key_pressed_i (key_pressed_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_code_o   (char_code_o),
    .shift_active_o(shift_active_o),
    .alt_layout_o  (alt_layout_o)
  );

  // Character per scan code; rows are Latin, Latin shifted, Cyrillic and
  // Cyrillic shifted.
  localparam logic [15:0] GLYPHS [4][58] = '{
    '{'h00, 'h00, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36,
      'h37, 'h38, 'h39, 'h30, 'h2D, 'h3D, 'h00, 'h00,
      'h71, 'h77, 'h65, 'h72, 'h74, 'h79, 'h75, 'h69,
      'h6F, 'h70, 'h5B, 'h5D, 'h00, 'h00, 'h61, 'h73,
      'h64, 'h66, 'h67, 'h68, 'h6A, 'h6B, 'h6C, 'h3B,
      'h27, 'h60, 'h00, 'h5C, 'h7A, 'h78, 'h63, 'h76,
      'h62, 'h6E, 'h6D, 'h2C, 'h2E, 'h2F, 'h00, 'h2A,
      'h00, 'h20},
    '{'h00, 'h00, 'h21, 'h40, 'h23, 'h24, 'h25, 'h5E,
      'h26, 'h2A, 'h28, 'h29, 'h5F, 'h2B, 'h00, 'h00,
      'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49,
      'h4F, 'h50, 'h7B, 'h7D, 'h00, 'h00, 'h41, 'h53,
      'h44, 'h46, 'h47, 'h48, 'h4A, 'h4B, 'h4C, 'h3A,
      'h22, 'h7E, 'h00, 'h7C, 'h5A, 'h58, 'h43, 'h56,
      'h42, 'h4E, 'h4D, 'h3C, 'h3E, 'h3F, 'h00, 'h2A,
      'h00, 'h20},
    '{'h00, 'h00, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36,
      'h37, 'h38, 'h39, 'h30, 'h2D, 'h3D, 'h00, 'h00,
      'h439, 'h446, 'h443, 'h43A, 'h435, 'h43D, 'h433, 'h448,
      'h449, 'h437, 'h445, 'h44A, 'h00, 'h00, 'h444, 'h44B,
      'h432, 'h430, 'h43F, 'h440, 'h43E, 'h43B, 'h434, 'h436,
      'h44D, 'h451, 'h00, 'h5C, 'h44F, 'h447, 'h441, 'h43C,
      'h438, 'h442, 'h44C, 'h431, 'h44E, 'h2E, 'h00, 'h2A,
      'h00, 'h20},
    '{'h00, 'h00, 'h21, 'h22, 'h2116, 'h3B, 'h25, 'h3A,
      'h3F, 'h2A, 'h28, 'h29, 'h5F, 'h2B, 'h00, 'h00,
      'h419, 'h426, 'h423, 'h41A, 'h415, 'h41D, 'h413, 'h428,
      'h429, 'h417, 'h425, 'h42A, 'h00, 'h00, 'h424, 'h42B,
      'h412, 'h410, 'h41F, 'h420, 'h41E, 'h41B, 'h414, 'h416,
      'h42D, 'h401, 'h00, 'h2F, 'h42F, 'h427, 'h421, 'h41C,
      'h418, 'h422, 'h42C, 'h411, 'h42E, 'h2C, 'h00, 'h2A,
      'h00, 'h20}
  };

  localparam logic [15:0] KEYPAD [13] = '{
    'h37, 'h38, 'h39, 'h2D, 'h34, 'h35, 'h36, 'h2B, 'h31, 'h32, 'h33, 'h30, 'h2E
  };

  typedef struct {
    logic [CharW-1:0] ch;
    logic             shift;
    logic             layout;
  } glyph_t;

  class keymap_tracker;
    bit     shift_down;
    bit     cyrillic;
    bit     mod_down;
    bit     shift_chord;
    bit     chord_armed;
    glyph_t pending_chars[$];
    int     failures;

    function new();
      shift_down  = 1'b0;
      cyrillic    = 1'b0;
      mod_down    = 1'b0;
      shift_chord = 1'b0;
      chord_armed = 1'b0;
      failures    = 0;
    endfunction

    function void log_keystroke(logic [CodeW-1:0] code, logic down);
      glyph_t     g;
      logic [1:0] row;
      if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
        shift_down  = down;
        shift_chord = down;
        if (down) begin
          if (mod_down) chord_armed = 1'b1;
        end else if (!mod_down && chord_armed) begin
          chord_armed = 1'b0;
          cyrillic    = !cyrillic;
        end
      end else if (code == KEY_LALT || code == KEY_LCTRL) begin
        mod_down = down;
        if (down) begin
          if (shift_chord) chord_armed = 1'b1;
        end else if (!shift_chord && chord_armed) begin
          chord_armed = 1'b0;
          cyrillic    = !cyrillic;
        end
      end else begin
        // Any other key breaks a chord in progress, press or release alike.
        mod_down    = 1'b0;
        shift_chord = 1'b0;
        chord_armed = 1'b0;
      end
      row  = {cyrillic, shift_down};
      g.ch = '0;
      if (down) begin
        if (code <= MAIN_LAST) g.ch = GLYPHS[row][code];
        else if (code >= PAD_FIRST && code <= PAD_LAST) g.ch = KEYPAD[code - PAD_FIRST];
        else if (code == KEY_DIVIDE) g.ch = 'h2F;
        else if (code == KEY_OEM102) g.ch = GLYPHS[row][KEY_BSLASH];
      end
      g.shift  = shift_down;
      g.layout = cyrillic;
      pending_chars.push_back(g);
    endfunction

    function void match_char(logic [CharW-1:0] ch, logic shift, logic layout);
      glyph_t g;
      if (pending_chars.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result char=%h shift=%b layout=%b",
                   $realtime, ch, shift, layout);
        return;
      end
      g = pending_chars.pop_front();
      if (g.ch !== ch || g.shift !== shift || g.layout !== layout) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch exp char=%h shift=%b layout=%b, got char=%h shift=%b layout=%b",
                   $realtime, g.ch, g.shift, g.layout, ch, shift, layout);
      end
    endfunction
  endclass

  keymap_tracker ledger = new();
  int unsigned   cycle_count   = 0;
  int unsigned   items_sent    = 0;
  int unsigned   results_taken = 0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) ledger.log_keystroke(key_code_i, key_pressed_i);
      if (out_valid_o && !out_stall_i)
        ledger.match_char(char_code_o, shift_active_o, alt_layout_o);
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("tb_scancode_to_char_layout_toggle_top: done, errors");
    $finish;
  end

  // Result side: a random hold before each result, quiet stretches with no
  // hold, and two long holds that back the block up into its request port.
  initial begin : result_sink
    int unsigned n;
    wait (rst_ni);
    forever begin
      if (results_taken == 30 || results_taken == 220) n = LongHold;
      else if (((results_taken / 20) % 3) == 2) n = 0;
      else n = $urandom_range(0, 8);
      @(negedge clk_i);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      results_taken++;
    end
  end

  task automatic press_key(input logic [CodeW-1:0] code, input logic down);
    int unsigned gap;
    gap = (((items_sent / 24) % 3) == 1) ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    key_code_i    <= code;
    key_pressed_i <= down;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  function automatic logic [CodeW-1:0] pick_code();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return CodeW'($urandom_range(0, MainCount - 1));
    if (sel < 17) return CodeW'($urandom_range(PAD_FIRST, PAD_LAST));
    if (sel == 17) return KEY_OEM102;
    if (sel == 18) return KEY_DIVIDE;
    return CodeW'($urandom_range(0, 255));
  endfunction

  initial begin : key_source
    logic [CodeW-1:0] mod_key;
    logic [CodeW-1:0] shift_key;
    int unsigned      n;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Table edges, keypad edges, unmapped ranges, divide and OEM 102.
    press_key(8'h10, 1'b1);
    press_key(8'h00, 1'b1);
    press_key(8'd57, 1'b1);
    press_key(8'd58, 1'b1);
    press_key(8'd70, 1'b1);
    press_key(PAD_FIRST, 1'b1);
    press_key(PAD_LAST, 1'b1);
    press_key(8'd84, 1'b1);
    press_key(KEY_DIVIDE, 1'b1);
    press_key(8'hFF, 1'b0);
    // Shift held changes the row, including the OEM 102 backslash entry.
    press_key(KEY_LSHIFT, 1'b1);
    press_key(KEY_OEM102, 1'b1);
    press_key(KEY_LSHIFT, 1'b0);
    // Ctrl then Shift, Shift released first: layout flips to Cyrillic.
    press_key(KEY_LCTRL, 1'b1);
    press_key(KEY_LSHIFT, 1'b1);
    press_key(KEY_LSHIFT, 1'b0);
    press_key(KEY_LCTRL, 1'b0);
    press_key(8'h10, 1'b1);
    // Shift, a key, then Alt, Alt released first: the key breaks the chord, no flip.
    press_key(KEY_RSHIFT, 1'b1);
    press_key(8'h04, 1'b1);
    press_key(KEY_LALT, 1'b1);
    press_key(KEY_LALT, 1'b0);
    press_key(KEY_RSHIFT, 1'b0);
    // A chord broken by another key does not flip the layout.
    press_key(KEY_LCTRL, 1'b1);
    press_key(8'h1E, 1'b0);

    while (items_sent < DirectedItems + RandomItems) begin
      mod_key   = $urandom_range(0, 1) ? KEY_LALT : KEY_LCTRL;
      shift_key = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 1)) begin
            press_key(mod_key, 1'b1);
            press_key(shift_key, 1'b1);
          end else begin
            press_key(shift_key, 1'b1);
            press_key(mod_key, 1'b1);
          end
          if ($urandom_range(0, 2) == 0) press_key(shift_key, 1'b1);
          if ($urandom_range(0, 1)) begin
            press_key(mod_key, 1'b0);
            press_key(shift_key, 1'b0);
          end else begin
            press_key(shift_key, 1'b0);
            press_key(mod_key, 1'b0);
          end
          press_key(pick_code(), 1'b1);
        end
        3, 4, 5: begin
          n = $urandom_range(1, 6);
          repeat (n) begin
            press_key(pick_code(), 1'b1);
            if ($urandom_range(0, 1)) press_key(pick_code(), 1'b0);
          end
        end
        6, 7: begin
          n = $urandom_range(1, 5);
          press_key(shift_key, 1'b1);
          repeat (n) press_key(pick_code(), 1'b1);
          press_key(shift_key, 1'b0);
        end
        8: begin
          n = $urandom_range(1, 4);
          repeat (n) press_key(CodeW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        default: begin
          press_key(mod_key, 1'b1);
          press_key(shift_key, 1'b1);
          press_key(CodeW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          press_key(shift_key, 1'b0);
          press_key(mod_key, 1'b0);
        end
      endcase
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.failures == 0) begin
      $display("tb_scancode_to_char_layout_toggle_top: done, clean");
    end else begin
      $display("tb_scancode_to_char_layout_toggle_top: done, errors");
    end
    $finish;
  end

endmodule
